@@ sv/rtpwa_pkg.sv @@
`timescale 1ns / 1ps

package rtpwa_pkg;

   // received byte codes
   localparam logic [7:0] CH_DIGIT_LO = 8'h30;
   localparam logic [7:0] CH_DIGIT_HI = 8'h39;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_LEFT     = 8'h4C;
   localparam logic [7:0] CH_RIGHT    = 8'h52;
   localparam logic [7:0] CH_FWD      = 8'h46;

   localparam int BYTE_W    = 8;
   localparam int READING_W = 7;
   localparam int DIR_W     = 2;

   localparam logic [READING_W-1:0] ACC_SAT     = 7'd100;
   localparam logic [READING_W-1:0] READING_MIN = 7'd10;
   localparam logic [READING_W-1:0] READING_MAX = 7'd99;

   localparam logic [DIR_W-1:0] DIR_LEFT    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd1;
   localparam logic [DIR_W-1:0] DIR_RIGHT   = 2'd2;

   // token kinds handed from the front end to the back end
   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_READING = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LEFT    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RIGHT   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FWD     = 3'd4;

   localparam int WINDOW_SIZE_DEF = 5;
   localparam int WINDOW_MAX      = 8;
   localparam int QUEUE_DEPTH     = 2;

   // mean by reciprocal multiply: exact for sums below 2**DIV_SHIFT / WINDOW_MAX
   localparam int DIV_SHIFT = 16;
   localparam int RECIP_W   = DIV_SHIFT + 1;

   localparam logic [READING_W-1:0] RING_INIT [WINDOW_MAX] =
      '{7'd44, 7'd54, 7'd42, 7'd56, 7'd42, 7'd0, 7'd0, 7'd0};

   typedef struct packed {
      logic [BYTE_W-1:0]    echo_byte;
      logic [KIND_W-1:0]    kind;
      logic [READING_W-1:0] value;
   } token_type;

   function automatic int ring_init_sum(input int entries);
      int sum;
      sum = 0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (i < entries) begin
            sum = sum + int'(RING_INIT[i]);
         end
      end
      return sum;
   endfunction

endpackage

@@ sv/rtpwa_front.sv @@
`timescale 1ns / 1ps

module rtpwa_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [7:0]           req_rx_byte,
   input  logic                 queue_full,
   output logic                 push,
   output rtpwa_pkg::token_type token
);

   logic [rtpwa_pkg::READING_W-1:0] acc_ff;
   logic [rtpwa_pkg::READING_W-1:0] acc_in;
   logic [9:0]                      acc_sum;
   logic [3:0]                      digit;

   assign push  = req_valid && !queue_full;
   assign digit = 4'(req_rx_byte - rtpwa_pkg::CH_DIGIT_LO);
   // acc * 10 + digit, at most 1009
   assign acc_sum = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + {6'd0, digit};

   always_comb begin
      acc_in          = acc_ff;
      token.echo_byte = req_rx_byte;
      token.kind      = rtpwa_pkg::KIND_NONE;
      token.value     = acc_ff;
      unique case (req_rx_byte) inside
         [rtpwa_pkg::CH_DIGIT_LO:rtpwa_pkg::CH_DIGIT_HI]: begin
            if (acc_sum > 10'(rtpwa_pkg::ACC_SAT)) begin
               acc_in = rtpwa_pkg::ACC_SAT;
            end else begin
               acc_in = acc_sum[rtpwa_pkg::READING_W-1:0];
            end
         end
         rtpwa_pkg::CH_QUOTE: begin
            acc_in = '0;
            if (acc_ff >= rtpwa_pkg::READING_MIN && acc_ff <= rtpwa_pkg::READING_MAX) begin
               token.kind = rtpwa_pkg::KIND_READING;
            end
         end
         rtpwa_pkg::CH_LEFT:  token.kind = rtpwa_pkg::KIND_LEFT;
         rtpwa_pkg::CH_RIGHT: token.kind = rtpwa_pkg::KIND_RIGHT;
         rtpwa_pkg::CH_FWD:   token.kind = rtpwa_pkg::KIND_FWD;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (push) begin
         acc_ff <= acc_in;
      end
   end

endmodule

@@ sv/rtpwa_queue.sv @@
`timescale 1ns / 1ps

module rtpwa_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rtpwa_pkg::token_type push_token,
   input  logic                 pop,
   output logic                 full,
   output logic                 valid,
   output rtpwa_pkg::token_type pop_token
);

   localparam int DEPTH = rtpwa_pkg::QUEUE_DEPTH;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rtpwa_pkg::token_type entry_ff [DEPTH];
   logic [IDX_W-1:0]     wr_ptr_ff;
   logic [IDX_W-1:0]     rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign valid     = (count_ff != '0);
   assign pop_token = entry_ff[rd_ptr_ff];

   function automatic logic [IDX_W-1:0] next_ptr(input logic [IDX_W-1:0] ptr);
      if (ptr == IDX_W'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ sv/rtpwa_back.sv @@
`timescale 1ns / 1ps

module rtpwa_back #(
   parameter int WINDOW_SIZE = rtpwa_pkg::WINDOW_SIZE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_valid,
   input  rtpwa_pkg::token_type queue_token,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_echo_byte,
   output logic [1:0]           rsp_steer_direction,
   output logic [6:0]           rsp_latest_reading,
   output logic [6:0]           rsp_window_average,
   output logic                 rsp_reading_accepted
);

   localparam int RW      = rtpwa_pkg::READING_W;
   localparam int IDX_W   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int SUM_W   = $clog2(99 * WINDOW_SIZE + 1);
   localparam int RECIP_W = rtpwa_pkg::RECIP_W;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << rtpwa_pkg::DIV_SHIFT) + WINDOW_SIZE - 1) / WINDOW_SIZE);
   localparam logic [SUM_W-1:0] SUM_RESET =
      SUM_W'(rtpwa_pkg::ring_init_sum(WINDOW_SIZE));

   // architectural state
   logic [RW-1:0]                 ring_ff [WINDOW_SIZE];
   logic [IDX_W-1:0]              ptr_ff;
   logic [SUM_W-1:0]              sum_ff;
   logic [SUM_W-1:0]              sum_in;
   logic [rtpwa_pkg::DIR_W-1:0]   dir_ff;
   logic [rtpwa_pkg::DIR_W-1:0]   dir_in;
   logic [RW-1:0]                 latest_ff;
   logic [RW-1:0]                 latest_in;
   logic                          is_reading;

   // middle stage: state applied, mean pending
   logic                          mid_valid_ff;
   logic [7:0]                    mid_echo_ff;
   logic [rtpwa_pkg::DIR_W-1:0]   mid_dir_ff;
   logic [RW-1:0]                 mid_latest_ff;
   logic                          mid_accepted_ff;
   logic [SUM_W-1:0]              mid_sum_ff;

   // result register
   logic                          rsp_valid_ff;
   logic [7:0]                    rsp_echo_ff;
   logic [rtpwa_pkg::DIR_W-1:0]   rsp_dir_ff;
   logic [RW-1:0]                 rsp_latest_ff;
   logic [RW-1:0]                 rsp_average_ff;
   logic                          rsp_accepted_ff;

   logic                          out_load;
   logic [PROD_W-1:0]             product;

   assign out_load   = mid_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop        = queue_valid && (!mid_valid_ff || out_load);
   assign is_reading = (queue_token.kind == rtpwa_pkg::KIND_READING);
   assign product    = PROD_W'(mid_sum_ff) * PROD_W'(RECIP);

   always_comb begin
      dir_in    = dir_ff;
      latest_in = latest_ff;
      sum_in    = sum_ff;
      unique case (queue_token.kind)
         rtpwa_pkg::KIND_READING: begin
            latest_in = queue_token.value;
            sum_in    = sum_ff - SUM_W'(ring_ff[ptr_ff]) + SUM_W'(queue_token.value);
         end
         rtpwa_pkg::KIND_LEFT:  dir_in = rtpwa_pkg::DIR_LEFT;
         rtpwa_pkg::KIND_RIGHT: dir_in = rtpwa_pkg::DIR_RIGHT;
         rtpwa_pkg::KIND_FWD:   dir_in = rtpwa_pkg::DIR_FORWARD;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_SIZE; i++) begin
            ring_ff[i] <= rtpwa_pkg::RING_INIT[i];
         end
         ptr_ff    <= '0;
         sum_ff    <= SUM_RESET;
         dir_ff    <= rtpwa_pkg::DIR_FORWARD;
         latest_ff <= '0;
      end else if (pop) begin
         dir_ff    <= dir_in;
         latest_ff <= latest_in;
         sum_ff    <= sum_in;
         if (is_reading) begin
            ring_ff[ptr_ff] <= queue_token.value;
            if (ptr_ff == IDX_W'(WINDOW_SIZE - 1)) begin
               ptr_ff <= '0;
            end else begin
               ptr_ff <= ptr_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (pop) begin
         mid_valid_ff <= 1'b1;
      end else if (out_load) begin
         mid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         mid_echo_ff     <= queue_token.echo_byte;
         mid_dir_ff      <= dir_in;
         mid_latest_ff   <= latest_in;
         mid_accepted_ff <= is_reading;
         mid_sum_ff      <= sum_in;
      end
   end

   // the held average is the current one until a reading replaces it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         rsp_average_ff <= '0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            if (mid_accepted_ff) begin
               rsp_average_ff <= product[rtpwa_pkg::DIV_SHIFT +: RW];
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_echo_ff     <= mid_echo_ff;
         rsp_dir_ff      <= mid_dir_ff;
         rsp_latest_ff   <= mid_latest_ff;
         rsp_accepted_ff <= mid_accepted_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_echo_byte        = rsp_echo_ff;
   assign rsp_steer_direction  = rsp_dir_ff;
   assign rsp_latest_reading   = rsp_latest_ff;
   assign rsp_window_average   = rsp_average_ff;
   assign rsp_reading_accepted = rsp_accepted_ff;

endmodule

@@ sv/rssi_token_parser_window_average.sv @@
`timescale 1ns / 1ps

// Channel    Direction  Handshake             Payload
// req        in         req_valid/req_stall   req_rx_byte
// rsp        out        rsp_valid/rsp_stall   rsp_echo_byte, rsp_steer_direction,
//                                             rsp_latest_reading, rsp_window_average,
//                                             rsp_reading_accepted
//
// One byte a cycle sustained while rsp_stall is low; each result turns valid once its byte
// has passed the queue write, middle stage and result register.
// The ring sum is kept running, so the mean is one reciprocal multiply in the last stage.
// Synchronous reset loads the ring with its initial readings.
// A stall on rsp backs up the result register, middle stage and two-entry queue
// before req_stall rises.

module rssi_token_parser_window_average #(
   parameter int WINDOW_SIZE = rtpwa_pkg::WINDOW_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_echo_byte,
   output logic [1:0] rsp_steer_direction,
   output logic [6:0] rsp_latest_reading,
   output logic [6:0] rsp_window_average,
   output logic       rsp_reading_accepted
);

   logic                 push;
   logic                 pop;
   logic                 queue_full;
   logic                 queue_valid;
   rtpwa_pkg::token_type push_token;
   rtpwa_pkg::token_type pop_token;

   assign req_stall = queue_full;

   rtpwa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .push        (push),
      .token       (push_token)
   );

   rtpwa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .full       (queue_full),
      .valid      (queue_valid),
      .pop_token  (pop_token)
   );

   rtpwa_back #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .queue_valid          (queue_valid),
      .queue_token          (pop_token),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_echo_byte        (rsp_echo_byte),
      .rsp_steer_direction  (rsp_steer_direction),
      .rsp_latest_reading   (rsp_latest_reading),
      .rsp_window_average   (rsp_window_average),
      .rsp_reading_accepted (rsp_reading_accepted)
   );

endmodule

@@ tb/sv/rssi_token_parser_window_average_tb.sv @@
`timescale 1ns / 1ps

module rssi_token_parser_window_average_tb;

   localparam int WIN = rtpwa_pkg::WINDOW_SIZE_DEF;

   typedef struct {
      logic [rtpwa_pkg::BYTE_W-1:0]    echo;
      logic [rtpwa_pkg::DIR_W-1:0]     dir;
      logic [rtpwa_pkg::READING_W-1:0] latest;
      logic [rtpwa_pkg::READING_W-1:0] average;
      logic                            accepted;
   } reading_report_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [rtpwa_pkg::BYTE_W-1:0]    req_rx_byte = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [rtpwa_pkg::BYTE_W-1:0]    rsp_echo_byte;
   logic [rtpwa_pkg::DIR_W-1:0]     rsp_steer_direction;
   logic [rtpwa_pkg::READING_W-1:0] rsp_latest_reading;
   logic [rtpwa_pkg::READING_W-1:0] rsp_window_average;
   logic                            rsp_reading_accepted;

   // predictor state
   logic [rtpwa_pkg::READING_W-1:0] acc_q;
   logic [rtpwa_pkg::READING_W-1:0] ring_q [WIN];
   int                              ring_ptr;
   logic [rtpwa_pkg::DIR_W-1:0]     dir_q;
   logic [rtpwa_pkg::READING_W-1:0] latest_q;
   logic [rtpwa_pkg::READING_W-1:0] average_q;

   reading_report_type pending_reports[$];
   int  error_count = 0;
   bit  idle_on = 1'b1;
   int  hold_left = 0;

   rssi_token_parser_window_average #(
      .WINDOW_SIZE(WIN)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_echo_byte(rsp_echo_byte),
      .rsp_steer_direction(rsp_steer_direction),
      .rsp_latest_reading(rsp_latest_reading),
      .rsp_window_average(rsp_window_average),
      .rsp_reading_accepted(rsp_reading_accepted)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("rssi_token_parser_window_average_tb: done, errors");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void clear_parser_state();
      acc_q = '0;
      for (int i = 0; i < WIN; i++) ring_q[i] = rtpwa_pkg::RING_INIT[i];
      ring_ptr = 0;
      dir_q = rtpwa_pkg::DIR_FORWARD;
      latest_q = '0;
      average_q = '0;
   endfunction

   function automatic reading_report_type parse_rx_byte(
      input logic [rtpwa_pkg::BYTE_W-1:0] b);
      reading_report_type r;
      int v;
      int sum;
      r.accepted = 1'b0;
      if (b >= rtpwa_pkg::CH_DIGIT_LO && b <= rtpwa_pkg::CH_DIGIT_HI) begin
         v = int'(acc_q) * 10 + int'(b - rtpwa_pkg::CH_DIGIT_LO);
         if (v > int'(rtpwa_pkg::ACC_SAT)) v = int'(rtpwa_pkg::ACC_SAT);
         acc_q = 7'(v);
      end
      if (b == rtpwa_pkg::CH_QUOTE) begin
         if (acc_q >= rtpwa_pkg::READING_MIN && acc_q <= rtpwa_pkg::READING_MAX) begin
            latest_q = acc_q;
            ring_q[ring_ptr] = acc_q;
            ring_ptr = (ring_ptr + 1 >= WIN) ? 0 : ring_ptr + 1;
            sum = 0;
            for (int i = 0; i < WIN; i++) sum += int'(ring_q[i]);
            average_q = 7'(sum / WIN);
            r.accepted = 1'b1;
         end
         acc_q = '0;
      end
      if (b == rtpwa_pkg::CH_LEFT) dir_q = rtpwa_pkg::DIR_LEFT;
      if (b == rtpwa_pkg::CH_RIGHT) dir_q = rtpwa_pkg::DIR_RIGHT;
      if (b == rtpwa_pkg::CH_FWD) dir_q = rtpwa_pkg::DIR_FORWARD;
      r.echo = b;
      r.dir = dir_q;
      r.latest = latest_q;
      r.average = average_q;
      return r;
   endfunction

   // valid stays high after the transfer; the next call or stop_source moves it
   task automatic send_byte(input logic [rtpwa_pkg::BYTE_W-1:0] b);
      int gap;
      bit taken;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      pending_reports.push_back(parse_rx_byte(b));
   endtask

   task automatic stop_source();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic send_digits(input int count, input bit nonzero_lead);
      for (int i = 0; i < count; i++) begin
         if (i == 0 && nonzero_lead) begin
            send_byte(8'(rtpwa_pkg::CH_DIGIT_LO + $urandom_range(1, 9)));
         end else begin
            send_byte(8'(rtpwa_pkg::CH_DIGIT_LO + $urandom_range(0, 9)));
         end
      end
   endtask

   task automatic send_direction();
      case ($urandom_range(0, 2))
         0: send_byte(rtpwa_pkg::CH_LEFT);
         1: send_byte(rtpwa_pkg::CH_RIGHT);
         default: send_byte(rtpwa_pkg::CH_FWD);
      endcase
   endtask

   task automatic send_random_token();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         send_digits(2, 1'b1);
         send_byte(rtpwa_pkg::CH_QUOTE);
      end else if (r < 67) begin
         send_digits($urandom_range(0, 5), 1'b0);
         send_byte(rtpwa_pkg::CH_QUOTE);
      end else if (r < 77) begin
         send_direction();
      end else if (r < 87) begin
         send_byte(8'($urandom_range(0, 255)));
      end else if (r < 91) begin
         send_byte(rtpwa_pkg::CH_QUOTE);
      end else begin
         // broken token: digits with no closing quote run into the next one
         send_digits($urandom_range(1, 3), 1'b0);
      end
   endtask

   task automatic test_directed_bytes();
      send_byte(8'h39); send_byte(8'h39); send_byte(rtpwa_pkg::CH_QUOTE);
      send_byte(8'h31); send_byte(8'h30); send_byte(rtpwa_pkg::CH_QUOTE);
      // leading zero, single digit, saturating run, empty token
      send_byte(8'h30); send_byte(8'h35); send_byte(rtpwa_pkg::CH_QUOTE);
      send_byte(8'h37); send_byte(rtpwa_pkg::CH_QUOTE);
      send_byte(8'h31); send_byte(8'h30); send_byte(8'h30);
      send_byte(rtpwa_pkg::CH_QUOTE);
      send_byte(rtpwa_pkg::CH_QUOTE);
      send_byte(rtpwa_pkg::CH_LEFT); send_byte(rtpwa_pkg::CH_RIGHT);
      send_byte(rtpwa_pkg::CH_FWD);
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'h2F); send_byte(8'h3A);
      stop_source();
   endtask

   task automatic test_random_traffic(input int items);
      for (int n = 0; n < items; n++) send_random_token();
   endtask

   task automatic test_output_backpressure();
      idle_on = 1'b0;
      hold_left = 300;
      for (int n = 0; n < 40; n++) send_random_token();
      idle_on = 1'b1;
   endtask

   task automatic test_pause_for_drain();
      for (int n = 0; n < 30; n++) send_random_token();
      stop_source();
      for (int n = 0; n < 30; n++) send_random_token();
   endtask

   // receiver: random stall runs, plus a long hold when requested
   initial begin
      int run;
      run = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (run > 0) begin
            rsp_stall <= 1'b1;
            run--;
         end else begin
            run = pick_gap();
            rsp_stall <= (run > 0);
            if (run > 0) run--;
         end
      end
   end

   task automatic compare_field(input string name, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         error_count++;
      end
   endtask

   // outputs and stall are stable at the falling edge, so a transfer is seen here
   always @(negedge clock) begin
      reading_report_type e;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $error("result with none expected: echo_byte %0d", rsp_echo_byte);
            error_count++;
         end else begin
            e = pending_reports.pop_front();
            compare_field("echo_byte", e.echo, rsp_echo_byte);
            compare_field("steer_direction", 8'(e.dir), 8'(rsp_steer_direction));
            compare_field("latest_reading", 8'(e.latest), 8'(rsp_latest_reading));
            compare_field("window_average", 8'(e.average), 8'(rsp_window_average));
            compare_field("reading_accepted", 8'(e.accepted),
                          8'(rsp_reading_accepted));
         end
      end
   end

   initial begin
      clear_parser_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_bytes();
      for (int phase = 0; phase < 6; phase++) begin
         idle_on = (phase % 3 != 2);
         test_random_traffic(105);
      end
      idle_on = 1'b1;
      test_output_backpressure();
      test_pause_for_drain();
      stop_source();
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("rssi_token_parser_window_average_tb: done, clean");
      end else begin
         $display("rssi_token_parser_window_average_tb: done, errors");
      end
      $finish;
   end

endmodule
